/* design/hnt_pkg.sv */
// Hello neighbor table: shared types, sizes and codes.
// No dependencies; used by every module of the block.
package hnt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int ADDR_BITS     = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int OP_W          = 2;
    localparam int IN_ADDR_W     = 16;
    localparam int TIME_W        = 32;
    localparam int SEQ_W         = 32;
    localparam int COUNT_OUT_W   = 6;
    localparam int LIFETIME_W    = 20;

    localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = LIFETIME_W'(4500);
    localparam logic [SEQ_W-1:0]      SEQ_RESET      = SEQ_W'(2);
    localparam logic [SEQ_W-1:0]      SEQ_STEP       = SEQ_W'(2);
    localparam logic [IDX_W-1:0]      LAST_IDX       = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [OP_W-1:0] {
        OP_HELLO  = 2'd0,
        OP_DELETE = 2'd1,
        OP_PURGE  = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_ABSENT   = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        op_t                    operation;
        logic [IN_ADDR_W-1:0]   neighbor_addr;
        logic [TIME_W-1:0]      now;
    } item_t;

    typedef struct packed {
        status_t                status;
        logic [COUNT_OUT_W-1:0] removed_count;
        logic [SEQ_W-1:0]       current_sequence;
        logic [COUNT_OUT_W-1:0] occupancy;
    } result_t;

    typedef struct packed {
        logic             load;
        logic             issue;
        logic [IDX_W-1:0] rd_idx;
        logic             finish;
    } cmd_t;

endpackage

/* design/hnt_ctrl.sv */
// Hello neighbor table controller: accepts a transaction, walks the table index,
// then commands the final update. Depends on hnt_pkg.
module hnt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output hnt_pkg::cmd_t cmd
);
    import hnt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             busy_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = S_DRAIN;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            S_DRAIN:  state_next = S_FINISH;
            S_FINISH: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy       = busy_reg;
    assign cmd.load   = start && (state_reg == S_IDLE);
    assign cmd.issue  = (state_reg == S_SCAN);
    assign cmd.rd_idx = idx_reg;
    assign cmd.finish = (state_reg == S_FINISH);

`ifndef SYNTHESIS
    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with state");

    a_load_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == S_SCAN) && (idx_reg == '0))
        else $error("accepted transaction did not start scan at entry zero");
`endif

endmodule

/* design/hnt_datapath.sv */
// Hello neighbor table datapath: entry memories, valid bits, counters,
// scan trackers and result register. Depends on hnt_pkg.
module hnt_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hnt_pkg::cmd_t                      cmd,
    input  hnt_pkg::item_t                     item,
    input  logic                               lifetime_we,
    input  logic [hnt_pkg::LIFETIME_W-1:0]     lifetime_wdata,
    output logic                               result_valid,
    output hnt_pkg::result_t                   result
);
    import hnt_pkg::*;

    logic [ADDR_BITS-1:0]     addr_mem [TABLE_ENTRIES];
    logic [TIME_W-1:0]        exp_mem  [TABLE_ENTRIES];

    // payload registers
    op_t                      op_reg;
    logic [ADDR_BITS-1:0]     addr_reg;
    logic [TIME_W-1:0]        now_reg;
    logic [ADDR_BITS-1:0]     rd_addr_reg;
    logic [TIME_W-1:0]        rd_exp_reg;
    logic [IDX_W-1:0]         cmp_idx_reg;
    result_t                  result_reg;

    // control registers
    logic [LIFETIME_W-1:0]    lifetime_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [SEQ_W-1:0]         seq_reg;
    logic [SEQ_W-1:0]         seq_next;
    logic [CNT_W-1:0]         removed_reg;
    logic [CNT_W-1:0]         removed_next;
    logic                     match_found_reg;
    logic                     match_found_next;
    logic [IDX_W-1:0]         match_idx_reg;
    logic [IDX_W-1:0]         match_idx_next;
    logic                     free_found_reg;
    logic                     free_found_next;
    logic [IDX_W-1:0]         free_idx_reg;
    logic [IDX_W-1:0]         free_idx_next;
    logic                     cmp_vld_reg;
    logic                     result_valid_reg;

    logic                     cur_valid;
    logic                     hit;
    logic                     expired;
    logic [TIME_W-1:0]        exp_sum;
    status_t                  status_next;
    logic                     wr_addr_en;
    logic                     wr_exp_en;
    logic [IDX_W-1:0]         wr_idx;

    assign cur_valid = valid_reg[cmp_idx_reg];
    assign hit       = cur_valid && (rd_addr_reg == addr_reg);
    assign expired   = cur_valid && (rd_exp_reg <= now_reg);
    assign exp_sum   = now_reg + TIME_W'(lifetime_reg);

    always_comb
    begin
        valid_next       = valid_reg;
        count_next       = count_reg;
        seq_next         = seq_reg;
        removed_next     = removed_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        status_next      = ST_FOUND;
        wr_addr_en       = 1'b0;
        wr_exp_en        = 1'b0;
        wr_idx           = match_idx_reg;

        if (cmd.load)
        begin
            removed_next     = '0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end

        if (cmp_vld_reg)
        begin
            if (hit && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = cmp_idx_reg;
            end
            if (!cur_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            if ((op_reg == OP_PURGE) && expired)
            begin
                valid_next[cmp_idx_reg] = 1'b0;
                count_next              = count_reg - CNT_W'(1);
                removed_next            = removed_reg + CNT_W'(1);
                seq_next                = seq_reg + SEQ_STEP;
            end
        end

        if (cmd.finish)
        begin
            unique case (op_reg)
                OP_HELLO:
                begin
                    if (match_found_reg)
                    begin
                        wr_exp_en   = 1'b1;
                        status_next = ST_FOUND;
                    end
                    else if (free_found_reg)
                    begin
                        wr_addr_en               = 1'b1;
                        wr_exp_en                = 1'b1;
                        wr_idx                   = free_idx_reg;
                        valid_next[free_idx_reg] = 1'b1;
                        count_next               = count_reg + CNT_W'(1);
                        seq_next                 = seq_reg + SEQ_STEP;
                        status_next              = ST_INSERTED;
                    end
                    else
                        status_next = ST_FULL;
                end
                OP_DELETE:
                begin
                    seq_next = seq_reg + SEQ_STEP;
                    if (match_found_reg)
                    begin
                        valid_next[match_idx_reg] = 1'b0;
                        count_next                = count_reg - CNT_W'(1);
                        removed_next              = CNT_W'(1);
                        status_next               = ST_FOUND;
                    end
                    else
                        status_next = ST_ABSENT;
                end
                OP_PURGE:  status_next = ST_FOUND;
                OP_LOOKUP: status_next = match_found_reg ? ST_FOUND : ST_ABSENT;
                default:   status_next = ST_FOUND;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_addr_en)
            addr_mem[wr_idx] <= addr_reg;
        if (wr_exp_en)
            exp_mem[wr_idx] <= exp_sum;
        if (cmd.issue)
        begin
            rd_addr_reg <= addr_mem[cmd.rd_idx];
            rd_exp_reg  <= exp_mem[cmd.rd_idx];
            cmp_idx_reg <= cmd.rd_idx;
        end
        if (cmd.load)
        begin
            op_reg   <= item.operation;
            addr_reg <= ADDR_BITS'(item.neighbor_addr);
            now_reg  <= item.now;
        end
        if (cmd.finish)
        begin
            result_reg.status           <= status_next;
            result_reg.removed_count    <= COUNT_OUT_W'(removed_next);
            result_reg.current_sequence <= seq_next;
            result_reg.occupancy        <= COUNT_OUT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lifetime_reg     <= LIFETIME_RESET;
            valid_reg        <= '0;
            count_reg        <= '0;
            seq_reg          <= SEQ_RESET;
            removed_reg      <= '0;
            match_found_reg  <= 1'b0;
            match_idx_reg    <= '0;
            free_found_reg   <= 1'b0;
            free_idx_reg     <= '0;
            cmp_vld_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (lifetime_we)
                lifetime_reg <= lifetime_wdata;
            valid_reg        <= valid_next;
            count_reg        <= count_next;
            seq_reg          <= seq_next;
            removed_reg      <= removed_next;
            match_found_reg  <= match_found_next;
            match_idx_reg    <= match_idx_next;
            free_found_reg   <= free_found_next;
            free_idx_reg     <= free_idx_next;
            cmp_vld_reg      <= cmd.issue;
            result_valid_reg <= cmd.finish;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("entry count differs from number of valid entries");

    a_seq_even: assert property (@(posedge clk) disable iff (!rst_n)
        seq_reg[0] == 1'b0)
        else $error("sequence number went odd");

    a_finish_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !cmp_vld_reg && !cmd.issue)
        else $error("update issued while scan still in flight");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("result strobe held longer than one cycle");
`endif

endmodule

/* design/hello_neighbor_table.sv */
// Hello neighbor table top level. The result strobe is registered from the finish
// state, which follows the scan and drain states. A new transaction is taken only
// after the last one is through: the walk visits one entry per cycle over the
// single-port entry memories, then drain, finish and a return to idle come before
// busy allows the next accept.
// Reset clears all valid bits at once, sequence to 2 and lifetime to 4500.
// The receiver cannot stall: each result is shown for exactly one cycle.
module hello_neighbor_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  hnt_pkg::item_t                 item,
    input  logic                           lifetime_we,
    input  logic [hnt_pkg::LIFETIME_W-1:0] lifetime_wdata,
    output logic                           result_valid,
    output hnt_pkg::result_t               result
);
    import hnt_pkg::*;

    cmd_t cmd;

    hnt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    hnt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .item           (item),
        .lifetime_we    (lifetime_we),
        .lifetime_wdata (lifetime_wdata),
        .result_valid   (result_valid),
        .result         (result)
    );

endmodule

/* sim/neighbor_table_checker.sv */
// Checker for the hello neighbor table: tracks lifetime writes and accepted
// transactions, predicts each result and compares it with the block's output.
// Depends on hnt_pkg.
`timescale 1ns / 1ps

module neighbor_table_checker
    import hnt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  item_t                 item,
    input  logic                  lifetime_we,
    input  logic [LIFETIME_W-1:0] lifetime_wdata,
    input  logic                  result_valid,
    input  result_t               result,
    output int                    mismatches,
    output int                    outstanding,
    output int                    compared
);

    bit                    slot_used   [TABLE_ENTRIES];
    logic [ADDR_BITS-1:0]  slot_addr   [TABLE_ENTRIES];
    logic [TIME_W-1:0]     slot_expiry [TABLE_ENTRIES];
    logic [SEQ_W-1:0]      set_sequence;
    int                    live_count;
    logic [LIFETIME_W-1:0] lifetime;
    result_t               pending_results[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        compared    = 0;
    end

    // Updates the predicted table for one transaction and returns its result.
    function automatic result_t apply_neighbor_item(item_t it);
        result_t              r;
        int                   hit;
        int                   free;
        int                   removed;
        logic [ADDR_BITS-1:0] addr;
        addr    = it.neighbor_addr[ADDR_BITS-1:0];
        removed = 0;
        hit     = -1;
        free    = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (slot_used[i] && slot_addr[i] == addr && hit < 0)
                hit = i;
            if (!slot_used[i] && free < 0)
                free = i;
        end
        r.status = ST_FOUND;
        case (it.operation)
            OP_HELLO:
            begin
                if (hit >= 0)
                    slot_expiry[hit] = it.now + TIME_W'(lifetime);
                else if (free < 0)
                    r.status = ST_FULL;
                else
                begin
                    slot_used[free]   = 1'b1;
                    slot_addr[free]   = addr;
                    slot_expiry[free] = it.now + TIME_W'(lifetime);
                    live_count++;
                    set_sequence += SEQ_STEP;
                    r.status = ST_INSERTED;
                end
            end
            OP_DELETE:
            begin
                set_sequence += SEQ_STEP;
                if (hit >= 0)
                begin
                    slot_used[hit] = 1'b0;
                    live_count--;
                    removed = 1;
                end
                else
                    r.status = ST_ABSENT;
            end
            OP_PURGE:
            begin
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (slot_used[i] && slot_expiry[i] <= it.now)
                    begin
                        slot_used[i] = 1'b0;
                        live_count--;
                        removed++;
                        set_sequence += SEQ_STEP;
                    end
                end
            end
            default:
            begin
                if (hit < 0)
                    r.status = ST_ABSENT;
            end
        endcase
        r.removed_count    = COUNT_OUT_W'(removed);
        r.current_sequence = set_sequence;
        r.occupancy        = COUNT_OUT_W'(live_count);
        return r;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                slot_used[i] = 1'b0;
            set_sequence = SEQ_RESET;
            live_count   = 0;
            lifetime     = LIFETIME_RESET;
            pending_results.delete();
            outstanding  = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (pending_results.size() == 0)
                    flag_error($sformatf("result %h with no transaction pending", result));
                else
                begin
                    want = pending_results.pop_front();
                    compared++;
                    if (result.status !== want.status
                        || result.removed_count !== want.removed_count
                        || result.current_sequence !== want.current_sequence
                        || result.occupancy !== want.occupancy)
                        flag_error($sformatf(
                            "mismatch: status %0d/%0d removed %0d/%0d seq %0d/%0d occ %0d/%0d (exp/act)",
                            want.status, result.status,
                            want.removed_count, result.removed_count,
                            want.current_sequence, result.current_sequence,
                            want.occupancy, result.occupancy));
                end
            end
            if (lifetime_we)
                lifetime = lifetime_wdata;
            if (start && !busy)
                pending_results.push_back(apply_neighbor_item(item));
            outstanding = pending_results.size();
        end
    end

endmodule

/* sim/hello_neighbor_table_tb.sv */
// Top-level testbench for hello_neighbor_table: drives directed and random
// transactions and lifetime settings; neighbor_table_checker does the checking.
// Depends on hnt_pkg, hello_neighbor_table and neighbor_table_checker.
`timescale 1ns / 1ps

module hello_neighbor_table_tb;
    import hnt_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 item;
    logic                  lifetime_we;
    logic [LIFETIME_W-1:0] lifetime_wdata;
    logic                  result_valid;
    result_t               result;
    int                    mismatches;
    int                    outstanding;
    int                    compared;

    int                    issued;
    int                    lifetime_writes;
    int                    max_gap;
    int                    cur_lifetime;
    logic [TIME_W-1:0]     tick;
    logic [IN_ADDR_W-1:0]  neighbor_pool [48];

    hello_neighbor_table dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .lifetime_we    (lifetime_we),
        .lifetime_wdata (lifetime_wdata),
        .result_valid   (result_valid),
        .result         (result)
    );

    neighbor_table_checker table_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .item           (item),
        .lifetime_we    (lifetime_we),
        .lifetime_wdata (lifetime_wdata),
        .result_valid   (result_valid),
        .result         (result),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .compared       (compared)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue_transaction(input op_t op, input logic [IN_ADDR_W-1:0] addr,
                                     input logic [TIME_W-1:0] stamp);
        item_t txn;
        int    gap;
        bit    taken;
        txn.operation     = op;
        txn.neighbor_addr = addr;
        txn.now           = stamp;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= txn;
        taken = 1'b0;
        while (!taken)
        begin
            taken = !busy;
            @(negedge clk);
        end
        issued++;
    endtask

    task automatic write_lifetime(input int value);
        start <= 1'b0;
        while (outstanding != 0 || busy)
            @(negedge clk);
        lifetime_we    <= 1'b1;
        lifetime_wdata <= LIFETIME_W'(value);
        @(negedge clk);
        lifetime_we    <= 1'b0;
        cur_lifetime = value;
        lifetime_writes++;
    endtask

    initial
    begin
        #(20_000_000);
        $display("hello_neighbor_table_tb failed");
        $finish;
    end

    initial
    begin
        logic [IN_ADDR_W-1:0] base;
        int                   pool_size;
        int                   step_max;
        int                   pick;
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        lifetime_we    = 1'b0;
        lifetime_wdata = '0;
        issued          = 0;
        lifetime_writes = 0;
        max_gap         = 7;
        cur_lifetime    = 4500;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty table, wrap of expiry, refresh, purge boundary, delete
        issue_transaction(OP_LOOKUP, 16'h0000, 32'd0);
        issue_transaction(OP_DELETE, 16'hFFFF, 32'd0);
        issue_transaction(OP_PURGE, 16'h0000, 32'd0);
        issue_transaction(OP_HELLO, 16'h0000, 32'd0);
        issue_transaction(OP_HELLO, 16'hFFFF, 32'hFFFF_FFFF);
        issue_transaction(OP_HELLO, 16'h0000, 32'd100);
        issue_transaction(OP_LOOKUP, 16'hFFFF, 32'd100);
        issue_transaction(OP_LOOKUP, 16'h5555, 32'd100);
        issue_transaction(OP_PURGE, 16'hAAAA, 32'd4499);
        issue_transaction(OP_PURGE, 16'h0000, 32'd4599);
        issue_transaction(OP_PURGE, 16'h0000, 32'd4600);
        issue_transaction(OP_HELLO, 16'hAAAA, 32'd4610);
        issue_transaction(OP_HELLO, 16'h5555, 32'd4610);
        issue_transaction(OP_DELETE, 16'hAAAA, 32'd4620);
        issue_transaction(OP_LOOKUP, 16'hAAAA, 32'd4620);
        issue_transaction(OP_DELETE, 16'hAAAA, 32'd4620);
        write_lifetime(0);
        issue_transaction(OP_HELLO, 16'h1234, 32'd5000);
        issue_transaction(OP_LOOKUP, 16'h1234, 32'd5000);
        issue_transaction(OP_PURGE, 16'h0000, 32'd5000);
        issue_transaction(OP_PURGE, 16'h0000, 32'hFFFF_FFFF);

        // fill to capacity, overflow, partial purge, then flush everything
        write_lifetime(1000);
        tick = $urandom();
        base = IN_ADDR_W'($urandom());
        for (int i = 0; i < TABLE_ENTRIES; i++)
            issue_transaction(OP_HELLO, base + IN_ADDR_W'(i), tick + TIME_W'(i));
        issue_transaction(OP_HELLO, base + 16'd32, tick + 32'd32);
        issue_transaction(OP_HELLO, base + 16'd40, tick + 32'd33);
        issue_transaction(OP_HELLO, base + 16'd5, tick + 32'd40);
        issue_transaction(OP_LOOKUP, base + 16'd31, tick + 32'd40);
        issue_transaction(OP_DELETE, base + 16'd3, tick + 32'd41);
        issue_transaction(OP_HELLO, base + 16'd100, tick + 32'd42);
        issue_transaction(OP_PURGE, 16'h0000, tick + 32'd1010);
        for (int i = 0; i < 24; i++)
            issue_transaction(OP_HELLO, ~base - IN_ADDR_W'(i), tick + 32'd1011);
        issue_transaction(OP_PURGE, 16'hFFFF, tick + 32'd5000);

        // random phases, each under its own lifetime setting
        for (int ph = 0; ph < 14; ph++)
        begin
            case (ph)
                0: write_lifetime(1);
                1: write_lifetime(20'hFFFFF);
                2: write_lifetime(1000000);
                3: write_lifetime(0);
                4: write_lifetime(4500);
                default:
                    write_lifetime(($urandom_range(0, 3) == 0) ? int'($urandom() & 32'hFFFFF)
                                                               : int'($urandom_range(2, 300)));
            endcase
            max_gap = (ph % 4 == 2) ? 0 : 7;
            case ($urandom_range(0, 2))
                0: pool_size = 6;
                1: pool_size = 24;
                default: pool_size = 48;
            endcase
            for (int i = 0; i < pool_size; i++)
                neighbor_pool[i] = IN_ADDR_W'($urandom());
            if (ph % 3 == 0)
                tick = $urandom();
            step_max = cur_lifetime / 8 + 4;
            for (int n = 0; n < 105; n++)
            begin
                pick = $urandom_range(0, 99);
                tick = tick + TIME_W'($urandom_range(0, step_max));
                if (pick < 45)
                    issue_transaction(OP_HELLO, neighbor_pool[$urandom_range(0, pool_size - 1)],
                                      tick);
                else if (pick < 60)
                    issue_transaction(OP_DELETE, neighbor_pool[$urandom_range(0, pool_size - 1)],
                                      tick);
                else if (pick < 75)
                    issue_transaction(OP_LOOKUP, neighbor_pool[$urandom_range(0, pool_size - 1)],
                                      tick);
                else if (pick < 88)
                    issue_transaction(OP_PURGE, IN_ADDR_W'($urandom()), tick);
                else if (pick < 93)
                begin
                    tick = tick + TIME_W'(2 * cur_lifetime + 1);
                    issue_transaction(OP_PURGE, IN_ADDR_W'($urandom()), tick);
                end
                else
                    issue_transaction(op_t'($urandom_range(0, 3)), IN_ADDR_W'($urandom()),
                                      $urandom());
            end
        end

        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("ran %0d transactions (%0d results compared) under %0d lifetime settings,",
                 issued, compared, lifetime_writes + 1);
        $display("including a full-table overflow and complete expiry flushes");
        if (mismatches == 0 && outstanding == 0)
            $display("hello_neighbor_table_tb passed");
        else
            $display("hello_neighbor_table_tb failed");
        $finish;
    end

endmodule

/* filelist.f */
design/hnt_pkg.sv
design/hnt_ctrl.sv
design/hnt_datapath.sv
design/hello_neighbor_table.sv
sim/neighbor_table_checker.sv
sim/hello_neighbor_table_tb.sv
